// File: src/miller_rabin_prime_test_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Miller-Rabin prime test
// Shorthand for clocked checks that are disabled while reset is active.
// ---------------------------------------------------------------------------
`ifndef MILLER_RABIN_PRIME_TEST_ASSERT_SVH
`define MILLER_RABIN_PRIME_TEST_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MRPT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MRPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/mrpt_pkg.sv
// ---------------------------------------------------------------------------
// Miller-Rabin prime test package
// Widths, the witness base table and the modular add used by the datapath.
// ---------------------------------------------------------------------------
package mrpt_pkg;

  localparam int NUM_W     = 64;
  localparam int WIDTH     = 64;
  localparam int NUM_BASES = 10;
  localparam int CNT_W     = $clog2(WIDTH);
  localparam int IDX_W     = 4;
  localparam logic [IDX_W-1:0] BASE_COUNT_RESET = IDX_W'(5);

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [IDX_W-1:0] idx_t;

  function automatic logic [4:0] witness_base(input idx_t idx);
    logic [4:0] b;
    case (idx)
      4'd0: b = 5'd2;
      4'd1: b = 5'd3;
      4'd2: b = 5'd5;
      4'd3: b = 5'd7;
      4'd4: b = 5'd11;
      4'd5: b = 5'd13;
      4'd6: b = 5'd17;
      4'd7: b = 5'd19;
      4'd8: b = 5'd23;
      4'd9: b = 5'd29;
      default: b = 5'd2;
    endcase
    return b;
  endfunction

  function automatic logic is_small_prime(input word_t n);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_BASES; i++) begin
      if (n == WIDTH'(witness_base(IDX_W'(i)))) hit = 1'b1;
    end
    return hit;
  endfunction

  // Sum of two residues below n, formed one bit wider and reduced once.
  function automatic word_t add_mod(input word_t x, input word_t y, input word_t n);
    logic [WIDTH:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, n}) s = s - {1'b0, n};
    return s[WIDTH-1:0];
  endfunction

endpackage

// File: src/mrpt_in_if.sv
// ---------------------------------------------------------------------------
// Miller-Rabin input channel
// Valid/ready channel that carries the number to be tested.
// ---------------------------------------------------------------------------
interface mrpt_in_if
  import mrpt_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink (input valid, input number, output ready);
endinterface

// File: src/mrpt_out_if.sv
// ---------------------------------------------------------------------------
// Miller-Rabin result channel
// Valid/ready channel that carries the prime verdict.
// ---------------------------------------------------------------------------
interface mrpt_out_if;
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink (input valid, input is_prime, output ready);
endinterface

// File: src/miller_rabin_prime_test.sv
// ---------------------------------------------------------------------------
// Miller-Rabin prime test
// Judges one 64-bit number per request with a shared shift-add-reduce unit.
// ---------------------------------------------------------------------------
// Channel   Direction  Payload            Handshake
// in_ch     in         number[63:0]       valid / ready
// out_ch    out        is_prime           valid / ready
// cfg       in         cfg_data[3:0]      cfg_we, no wait
//
// Small primes, numbers below two and even numbers go straight from idle to done.
// Otherwise a request splits n - 1 into m * 2^k and then, per base, raises the
// base to the power m and squares the result up to k times, each modular
// product running on the one shift-add-reduce unit.
// Reset clears the sequencer and sets base_count to five.
// The block takes no request while one is in work or its result is unread.
// ---------------------------------------------------------------------------
module miller_rabin_prime_test
  import mrpt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  mrpt_in_if.sink           in_ch,
  mrpt_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_data
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SPLIT  = 4'd1;
  localparam logic [3:0] S_LOAD   = 4'd2;
  localparam logic [3:0] S_REDUCE = 4'd3;
  localparam logic [3:0] S_POW    = 4'd4;
  localparam logic [3:0] S_MUL    = 4'd5;
  localparam logic [3:0] S_CHECK  = 4'd6;
  localparam logic [3:0] S_SQL    = 4'd7;
  localparam logic [3:0] S_NEXT   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  localparam logic [1:0] MOP_R  = 2'd0;
  localparam logic [1:0] MOP_SQ = 2'd1;
  localparam logic [1:0] MOP_U  = 2'd2;

  localparam word_t ONE = WIDTH'(1);

  logic [3:0] state_r, state_nxt;
  logic [1:0] mop_r, mop_nxt;
  idx_t       base_count_r;
  idx_t       base_idx_r, base_idx_nxt;
  idx_t       rounds_r, rounds_nxt;
  cnt_t       k_r, k_nxt;
  cnt_t       j_r, j_nxt;
  word_t      n_r, n_nxt;
  word_t      nm1_r, nm1_nxt;
  word_t      m_r, m_nxt;
  word_t      r_r, r_nxt;
  word_t      sq_r, sq_nxt;
  word_t      e_r, e_nxt;
  word_t      acc_r, acc_nxt;
  word_t      x_r, x_nxt;
  word_t      y_r, y_nxt;
  logic       result_r, result_nxt;

  word_t      in_n;
  idx_t       rounds_in;
  word_t      step_acc;
  word_t      step_x;
  logic       take_small;
  logic       take_even;

  assign in_n = in_ch.number[WIDTH-1:0];

  always_comb begin
    if (base_count_r == '0) begin
      rounds_in = IDX_W'(1);
    end else if (base_count_r > IDX_W'(NUM_BASES)) begin
      rounds_in = IDX_W'(NUM_BASES);
    end else begin
      rounds_in = base_count_r;
    end
  end

  // The shared shift-add-reduce unit: one bit of the multiplier per cycle.
  assign step_acc = y_r[0] ? add_mod(acc_r, x_r, n_r) : acc_r;
  assign step_x   = add_mod(x_r, x_r, n_r);

  assign in_ch.ready     = (state_r == S_IDLE);
  assign out_ch.valid    = (state_r == S_DONE);
  assign out_ch.is_prime = result_r;

  always_comb begin
    state_nxt    = state_r;
    mop_nxt      = mop_r;
    base_idx_nxt = base_idx_r;
    rounds_nxt   = rounds_r;
    k_nxt        = k_r;
    j_nxt        = j_r;
    n_nxt        = n_r;
    nm1_nxt      = nm1_r;
    m_nxt        = m_r;
    r_nxt        = r_r;
    sq_nxt       = sq_r;
    e_nxt        = e_r;
    acc_nxt      = acc_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    result_nxt   = result_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          n_nxt        = in_n;
          nm1_nxt      = {in_n[WIDTH-1:1], 1'b0};
          m_nxt        = {in_n[WIDTH-1:1], 1'b0};
          k_nxt        = '0;
          base_idx_nxt = '0;
          rounds_nxt   = rounds_in;
          if (is_small_prime(in_n)) begin
            result_nxt = 1'b1;
            state_nxt  = S_DONE;
          end else if (in_n < WIDTH'(2) || !in_n[0]) begin
            result_nxt = 1'b0;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_SPLIT;
          end
        end
      end
      S_SPLIT: begin
        if (!m_r[0]) begin
          m_nxt = m_r >> 1;
          k_nxt = k_r + CNT_W'(1);
        end else begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        sq_nxt    = WIDTH'(witness_base(base_idx_r));
        r_nxt     = ONE;
        e_nxt     = m_r;
        state_nxt = S_REDUCE;
      end
      S_REDUCE: begin
        if (sq_r >= n_r) begin
          sq_nxt = sq_r - n_r;
        end else begin
          state_nxt = S_POW;
        end
      end
      S_POW: begin
        acc_nxt = '0;
        if (e_r == '0) begin
          state_nxt = S_CHECK;
        end else if (e_r[0]) begin
          x_nxt     = r_r;
          y_nxt     = sq_r;
          mop_nxt   = MOP_R;
          state_nxt = S_MUL;
        end else begin
          x_nxt     = sq_r;
          y_nxt     = sq_r;
          mop_nxt   = MOP_SQ;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (y_r != '0) begin
          acc_nxt = step_acc;
          x_nxt   = step_x;
          y_nxt   = y_r >> 1;
        end else begin
          case (mop_r)
            MOP_R: begin
              r_nxt   = acc_r;
              acc_nxt = '0;
              x_nxt   = sq_r;
              y_nxt   = sq_r;
              mop_nxt = MOP_SQ;
            end
            MOP_SQ: begin
              sq_nxt    = acc_r;
              e_nxt     = e_r >> 1;
              state_nxt = S_POW;
            end
            MOP_U: begin
              if (acc_r == ONE && r_r != ONE && r_r != nm1_r) begin
                result_nxt = 1'b0;
                state_nxt  = S_DONE;
              end else begin
                r_nxt     = acc_r;
                j_nxt     = j_r + CNT_W'(1);
                state_nxt = S_SQL;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_CHECK: begin
        j_nxt = '0;
        if (r_r == ONE) begin
          state_nxt = S_NEXT;
        end else begin
          state_nxt = S_SQL;
        end
      end
      S_SQL: begin
        if (j_r == k_r) begin
          if (r_r != ONE) begin
            result_nxt = 1'b0;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_NEXT;
          end
        end else begin
          acc_nxt   = '0;
          x_nxt     = r_r;
          y_nxt     = r_r;
          mop_nxt   = MOP_U;
          state_nxt = S_MUL;
        end
      end
      S_NEXT: begin
        if (base_idx_r + IDX_W'(1) == rounds_r) begin
          result_nxt = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          base_idx_nxt = base_idx_r + IDX_W'(1);
          state_nxt    = S_LOAD;
        end
      end
      S_DONE: begin
        if (out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mop_r        <= MOP_R;
      base_count_r <= BASE_COUNT_RESET;
    end else begin
      state_r <= state_nxt;
      mop_r   <= mop_nxt;
      if (cfg_we) begin
        base_count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    base_idx_r <= base_idx_nxt;
    rounds_r   <= rounds_nxt;
    k_r        <= k_nxt;
    j_r        <= j_nxt;
    n_r        <= n_nxt;
    nm1_r      <= nm1_nxt;
    m_r        <= m_nxt;
    r_r        <= r_nxt;
    sq_r       <= sq_nxt;
    e_r        <= e_nxt;
    acc_r      <= acc_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    result_r   <= result_nxt;
  end

  assign take_small = in_ch.valid && in_ch.ready && is_small_prime(in_n);
  assign take_even  = in_ch.valid && in_ch.ready && !in_n[0] && in_n != WIDTH'(2);

`include "miller_rabin_prime_test_assert.svh"

  `MRPT_ASSERT_SAME(a_ready_excl, in_ch.ready, !out_ch.valid, "ready while a result waits")
  `MRPT_ASSERT_SAME(a_acc_reduced, state_r == S_MUL, acc_r < n_r && x_r < n_r, "residue not reduced")
  `MRPT_ASSERT_SAME(a_split_nonzero, state_r == S_SPLIT, m_r != '0, "odd part search on zero")
  `MRPT_ASSERT_NEXT(a_small_prime, take_small, out_ch.valid && result_r, "small prime missed")
  `MRPT_ASSERT_NEXT(a_even, take_even, out_ch.valid && !result_r, "even number not rejected")

endmodule

// File: tb/miller_rabin_prime_test_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Miller-Rabin prime test testbench
// Sends numbers through the request channel and checks every verdict against
// a behavioral prime judge kept in step with the base count register. The
// directed tests cover the trivial numbers, the width extremes, the limits of
// the base count and strong pseudoprimes. Further tests apply backpressure
// and several random phases, all but one with random idling on both channels.
// ---------------------------------------------------------------------------
module miller_rabin_prime_test_tb;
  import mrpt_pkg::*;

  localparam logic [5*NUM_BASES-1:0] TRIAL_BASES =
    {5'd29, 5'd23, 5'd19, 5'd17, 5'd13, 5'd11, 5'd7, 5'd5, 5'd3, 5'd2};

  typedef struct packed {
    word_t number;
    logic  is_prime;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  idx_t cfg_data;

  mrpt_in_if  in_ch();
  mrpt_out_if out_ch();

  verdict_t verdict_q[$];
  idx_t     witness_count;
  int       mismatch_count;
  int       in_gap;
  bit       in_idle;
  bit       out_idle;
  bit       in_offering;
  int       hold_cycles;
  bit       hold_active;

  miller_rabin_prime_test dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic word_t wrap_sum(input word_t a, input word_t b, input word_t n);
    logic [WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, n}) ? word_t'(s - {1'b0, n}) : word_t'(s);
  endfunction

  function automatic word_t product_mod(input word_t a, input word_t b, input word_t n);
    word_t acc;
    acc = '0;
    while (b != 0) begin
      if (b[0]) acc = wrap_sum(acc, a, n);
      a = wrap_sum(a, a, n);
      b = b >> 1;
    end
    return acc;
  endfunction

  function automatic word_t power_mod(input word_t b, input word_t e, input word_t n);
    word_t r;
    word_t sq;
    r = word_t'(1);
    sq = b % n;
    while (e != 0) begin
      if (e[0]) r = product_mod(r, sq, n);
      sq = product_mod(sq, sq, n);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic logic judge_number(input word_t n, input idx_t count);
    word_t m;
    word_t u;
    word_t sq;
    int    k;
    int    rounds;
    for (int i = 0; i < NUM_BASES; i++) begin
      if (n == word_t'(TRIAL_BASES[i*5 +: 5])) return 1'b1;
    end
    if (n < 2 || !n[0]) return 1'b0;
    m = n - 1;
    k = 0;
    while (!m[0]) begin
      k++;
      m = m >> 1;
    end
    rounds = (count == 0) ? 1 : ((count > NUM_BASES) ? NUM_BASES : int'(count));
    for (int i = 0; i < rounds; i++) begin
      u = power_mod(word_t'(TRIAL_BASES[i*5 +: 5]), m, n);
      if (u == 1) continue;
      for (int j = 0; j < k; j++) begin
        sq = product_mod(u, u, n);
        if (sq == 1 && u != 1 && u != n - 1) return 1'b0;
        u = sq;
      end
      if (u != 1) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic word_t next_probable_prime(input word_t start);
    word_t n;
    n = start | word_t'(1);
    while (!judge_number(n, idx_t'(NUM_BASES))) n = n + 2;
    return n;
  endfunction

  function automatic word_t draw_number();
    int    pick;
    int    w;
    word_t n;
    pick = $urandom_range(0, 99);
    n = {$urandom, $urandom};
    if (pick < 8) begin
      n = word_t'($urandom_range(0, 40));
    end else if (pick < 20) begin
      n[0] = 1'b0;
    end else if (pick < 45) begin
      n = next_probable_prime(word_t'($urandom_range(128, 65535)));
    end else if (pick < 55) begin
      n = next_probable_prime(word_t'($urandom_range(17, 1023))) *
          next_probable_prime(word_t'($urandom_range(17, 1023)));
    end else if (pick < 58) begin
      n[0] = 1'b1;
    end else begin
      w = $urandom_range(8, 24);
      n = (n & ((word_t'(1) << w) - 1)) | word_t'(1);
    end
    return n;
  endfunction

  task automatic offer_number(input word_t n);
    verdict_t v;
    repeat (in_gap) @(posedge clk);
    in_ch.valid  <= 1'b1;
    in_ch.number <= n;
    in_offering  = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    v.number   = n;
    v.is_prime = judge_number(n, witness_count);
    verdict_q.push_back(v);
    in_gap = in_idle ? $urandom_range(0, 17) : 0;
    if (in_gap > 0) begin
      in_ch.valid <= 1'b0;
      in_offering = 1'b0;
    end
  endtask

  task automatic drain_results();
    if (in_offering) begin
      in_ch.valid <= 1'b0;
      in_offering = 1'b0;
    end
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_base_count(input idx_t value);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    witness_count = value;
  endtask

  task automatic test_trivial_numbers();
    offer_number(64'd0);
    offer_number(64'd1);
    offer_number(64'd2);
    offer_number(64'd3);
    offer_number(64'd29);
    offer_number(64'd4);
    offer_number(64'd31);
    offer_number(64'd9);
    offer_number(64'd561);
    offer_number(64'h8000_0000_0000_0000);
    offer_number(64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_base_count_limits();
    write_base_count(idx_t'(1));
    offer_number(64'd2047);
    write_base_count(idx_t'(0));
    offer_number(64'd2047);
    write_base_count(idx_t'(2));
    offer_number(64'd2047);
    write_base_count(idx_t'(4));
    offer_number(64'd3215031751);
    write_base_count(idx_t'(5));
    offer_number(64'd3215031751);
    write_base_count(idx_t'(15));
    offer_number(64'hFFFF_FFFF_FFFF_FFC5);
    write_base_count(idx_t'(10));
    offer_number(64'h1FFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_backpressure();
    drain_results();
    hold_cycles = 300;
    wait (hold_active);
    offer_number(64'd6);
    offer_number(64'd1048573);
    offer_number(64'd13);
    offer_number(64'd1);
    offer_number(64'd65535);
    drain_results();
  endtask

  task automatic test_random_numbers();
    for (int phase = 0; phase < 4; phase++) begin
      in_idle  = (phase != 1);
      out_idle = (phase != 1);
      write_base_count(idx_t'($urandom_range(0, 15)));
      for (int i = 0; i < 25; i++) begin
        if ($urandom_range(0, 19) == 0) drain_results();
        offer_number(draw_number());
      end
    end
  endtask

  always @(posedge clk) begin
    verdict_t v;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (verdict_q.size() == 0) begin
        $error("is_prime: expected none, actual %0b", out_ch.is_prime);
        mismatch_count++;
      end else begin
        v = verdict_q.pop_front();
        if (out_ch.is_prime !== v.is_prime) begin
          $error("is_prime for %0d: expected %0b, actual %0b",
                 v.number, v.is_prime, out_ch.is_prime);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int stall;
    int n;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        out_ch.ready <= 1'b0;
        hold_active = 1'b1;
        repeat (n) @(posedge clk);
        hold_active = 1'b0;
      end
      stall = out_idle ? $urandom_range(0, 17) : 0;
      if ($urandom_range(0, 1) == 1) begin
        out_ch.ready <= 1'b0;
        do @(posedge clk); while (!out_ch.valid && hold_cycles == 0);
        if (!out_ch.valid) continue;
        repeat (stall) @(posedge clk);
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        do @(posedge clk); while (!out_ch.valid && hold_cycles == 0);
      end
    end
  end

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_data       <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.number   <= '0;
    witness_count  = BASE_COUNT_RESET;
    mismatch_count = 0;
    in_gap         = 0;
    in_idle        = 1'b1;
    out_idle       = 1'b1;
    in_offering    = 1'b0;
    hold_cycles    = 0;
    hold_active    = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_trivial_numbers();
    test_base_count_limits();
    test_backpressure();
    test_random_numbers();

    drain_results();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
